// ===== design/multi_slot_timer_scheduler_assert.svh =====
// Assertion macros shared by the timer scheduler RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n.
`ifndef MULTI_SLOT_TIMER_SCHEDULER_ASSERT_SVH
`define MULTI_SLOT_TIMER_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("timer scheduler check failed");

// Next-cycle implication, checked outside reset.
`define MST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("timer scheduler check failed");

`endif

// ===== design/mst_pkg.sv =====
// Shared types and constants of the multi-slot timer scheduler.
// No dependencies.
package mst_pkg;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_CREATE = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_RESET  = 3'd4;
    localparam logic [2:0] OP_CHANGE = 3'd5;

    // Most expiries reported on one tick, and the width of a counter of them.
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  timer_id;
        logic [31:0] period;
        logic        reload_en;
    } t_in;

    typedef struct packed {
        logic [2:0] fired_timer;
        logic       last_fired;
    } t_out;

    typedef struct packed {
        logic [63:0] expiry;
        logic [31:0] period;
        logic [63:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ===== design/multi_slot_timer_scheduler.sv =====
// Top level of the multi-slot timer scheduler.
// Depends on mst_pkg, mst_front and mst_back (which uses mst_ram).
//
//   channel   | ports                         | handshake
//   ----------+-------------------------------+-------------------------------
//   command   | start, busy, i_cmd            | beat taken when start && !busy
//   result    | o_valid, o_result             | one-cycle strobe, no back-pressure
//
// A command beat enters a two-entry queue, so busy rises only when the queue
// is full. Create, start, stop and change period are done in the back part
// straight from idle; reset of an active slot also passes through S_RSTWR,
// since it reads the slot table. A tick scans the table even when nothing is
// due, and every report needs a full scan of the slot table through its one
// read port, plus a report state (S_FIRE) and a re-arm state (S_WRITE).
// Reset is synchronous and active low; it empties the queue, clears time,
// arming order and all active and periodic marks. The receiver cannot stall.
module multi_slot_timer_scheduler #(
    parameter int NUM_TIMERS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  mst_pkg::t_in  i_cmd,
    output logic          o_valid,
    output mst_pkg::t_out o_result
);
    import mst_pkg::*;

    // Queue head handed from the front part to the back part.
    t_in  w_q_cmd;
    logic w_q_valid;
    logic w_q_pop;

    mst_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_cmd   (i_cmd),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    // The back part scans slots in order of expiry, then of arming order,
    // with the lower slot first on a full tie.
    mst_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_q_pop),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );
endmodule

// ===== design/mst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/mst_front.sv =====
// Front part: takes command beats, drops those that address no slot or carry
// an unknown op, and queues the rest. Depends on mst_pkg.
module mst_front #(
    parameter int NUM_TIMERS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    output logic         o_busy,
    input  mst_pkg::t_in i_cmd,
    output logic         o_valid,
    output mst_pkg::t_in o_cmd,
    input  logic         i_pop
);
    import mst_pkg::*;

    t_in        r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_keep;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        case (i_cmd.op)
            OP_TICK:   w_keep = 1'b1;
            OP_CREATE, OP_START, OP_STOP, OP_RESET, OP_CHANGE:
                       w_keep = ({29'd0, i_cmd.timer_id} < 32'(NUM_TIMERS));
            default:   w_keep = 1'b0;
        endcase
    end

    assign o_busy  = (r_cnt == 2'd2);
    assign w_push  = i_start && !o_busy && w_keep;
    assign w_pop   = i_pop && (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];

    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end
endmodule

// ===== design/mst_back.sv =====
// Back part: carries out queued commands against the slot table and scans
// the slots on each tick. Depends on mst_pkg, mst_ram and the assert header.
`include "multi_slot_timer_scheduler_assert.svh"

module mst_back #(
    parameter int NUM_TIMERS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  mst_pkg::t_in  i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    output mst_pkg::t_out o_result
);
    import mst_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = IW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FIRE  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_RSTWR = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [63:0]      r_now, n_now;
    logic [63:0]      r_stamp, n_stamp;
    logic             r_active [NUM_TIMERS];
    logic             n_active [NUM_TIMERS];
    logic             r_periodic [NUM_TIMERS];
    logic             n_periodic [NUM_TIMERS];
    logic [CW-1:0]    r_scan, n_scan;
    logic             r_ev, n_ev;
    logic [IW-1:0]    r_ev_idx, n_ev_idx;
    logic             r_found, n_found;
    logic [IW-1:0]    r_best, n_best;
    logic [63:0]      r_best_exp, n_best_exp;
    logic [63:0]      r_best_stamp, n_best_stamp;
    logic [31:0]      r_best_per, n_best_per;
    logic             r_first, n_first;
    logic [CNT_W-1:0] r_due, n_due;
    logic [CNT_W-1:0] r_fired, n_fired;
    logic [63:0]      r_sum_a, n_sum_a;
    logic [63:0]      r_sum_b, n_sum_b;
    logic [IW-1:0]    r_id, n_id;

    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_entry        w_wdata;
    logic [IW-1:0] w_raddr;
    t_entry        w_rdata;
    logic [ENTRY_W-1:0] w_rbits;
    logic [IW-1:0] w_cid;
    logic [31:0]   w_cper;
    logic          w_due;
    logic          w_better;
    logic [63:0]   w_nx;

    mst_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_TIMERS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rbits)
    );
    assign w_rdata = t_entry'(w_rbits);

    assign w_cid  = IW'(i_cmd.timer_id);
    assign w_cper = (i_cmd.period == 32'd0) ? 32'd1 : i_cmd.period;

    assign w_due    = r_active[r_ev_idx] && (w_rdata.expiry <= r_now);
    assign w_better = !r_found || (w_rdata.expiry < r_best_exp) ||
                      ((w_rdata.expiry == r_best_exp) && (w_rdata.stamp < r_best_stamp));
    assign w_nx     = (r_sum_a <= r_now) ? r_sum_b : r_sum_a;

    assign o_valid              = (r_state == S_FIRE);
    assign o_result.fired_timer = 3'(r_best);
    assign o_result.last_fired  = ((r_fired + CNT_W'(1)) == r_due);

    always_comb begin
        n_state      = r_state;
        n_now        = r_now;
        n_stamp      = r_stamp;
        n_active     = r_active;
        n_periodic   = r_periodic;
        n_scan       = r_scan;
        n_ev         = 1'b0;
        n_ev_idx     = r_ev_idx;
        n_found      = r_found;
        n_best       = r_best;
        n_best_exp   = r_best_exp;
        n_best_stamp = r_best_stamp;
        n_best_per   = r_best_per;
        n_first      = r_first;
        n_due        = r_due;
        n_fired      = r_fired;
        n_sum_a      = r_sum_a;
        n_sum_b      = r_sum_b;
        n_id         = r_id;
        o_pop        = 1'b0;
        w_we         = 1'b0;
        w_waddr      = w_cid;
        w_wdata      = '{expiry: r_now + {32'd0, w_cper}, period: w_cper, stamp: r_stamp};
        w_raddr      = r_scan[IW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_TICK: begin
                            n_now   = r_now + 64'd1;
                            n_first = 1'b1;
                            n_due   = '0;
                            n_fired = '0;
                            n_found = 1'b0;
                            n_scan  = '0;
                            n_state = S_SCAN;
                        end
                        OP_CREATE: begin
                            n_active[w_cid]   = 1'b0;
                            n_periodic[w_cid] = i_cmd.reload_en;
                        end
                        OP_START: begin
                            w_we            = 1'b1;
                            n_active[w_cid] = 1'b1;
                            n_stamp         = r_stamp + 64'd1;
                        end
                        OP_STOP: begin
                            n_active[w_cid] = 1'b0;
                        end
                        OP_RESET: begin
                            if (r_active[w_cid]) begin
                                w_raddr = w_cid;
                                n_id    = w_cid;
                                n_state = S_RSTWR;
                            end
                        end
                        OP_CHANGE: begin
                            // An idle slot gets the whole entry written, but start rewrites all
                            // of it, period included, from its own command.
                            w_we = 1'b1;
                            if (r_active[w_cid]) begin
                                n_stamp = r_stamp + 64'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RSTWR: begin
                w_we    = 1'b1;
                w_waddr = r_id;
                w_wdata = '{expiry: r_now + {32'd0, w_rdata.period},
                            period: w_rdata.period, stamp: r_stamp};
                n_stamp = r_stamp + 64'd1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (r_scan != CW'(NUM_TIMERS)) begin
                    n_ev     = 1'b1;
                    n_ev_idx = r_scan[IW-1:0];
                    n_scan   = r_scan + CW'(1);
                end
                if (r_ev && w_due) begin
                    if (r_first && (r_due != CNT_W'(MAX_RESULTS))) begin
                        n_due = r_due + CNT_W'(1);
                    end
                    if (w_better) begin
                        n_found      = 1'b1;
                        n_best       = r_ev_idx;
                        n_best_exp   = w_rdata.expiry;
                        n_best_stamp = w_rdata.stamp;
                        n_best_per   = w_rdata.period;
                    end
                end
                if ((r_scan == CW'(NUM_TIMERS)) && !r_ev) begin
                    n_state = r_found ? S_FIRE : S_IDLE;
                end
            end
            S_FIRE: begin
                n_fired = r_fired + CNT_W'(1);
                n_sum_a = r_best_exp + {32'd0, r_best_per};
                n_sum_b = r_now + {32'd0, r_best_per};
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (r_periodic[r_best]) begin
                    w_we    = 1'b1;
                    w_waddr = r_best;
                    w_wdata = '{expiry: w_nx, period: r_best_per, stamp: r_stamp};
                    n_stamp = r_stamp + 64'd1;
                end else begin
                    n_active[r_best] = 1'b0;
                end
                n_first = 1'b0;
                n_found = 1'b0;
                n_scan  = '0;
                n_state = (r_fired == r_due) ? S_IDLE : S_SCAN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_now   <= '0;
            r_stamp <= '0;
            r_ev    <= 1'b0;
            r_found <= 1'b0;
            r_first <= 1'b0;
            r_due   <= '0;
            r_fired <= '0;
            r_scan  <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_active[i]   <= 1'b0;
                r_periodic[i] <= 1'b0;
            end
        end else begin
            r_state    <= n_state;
            r_now      <= n_now;
            r_stamp    <= n_stamp;
            r_ev       <= n_ev;
            r_found    <= n_found;
            r_first    <= n_first;
            r_due      <= n_due;
            r_fired    <= n_fired;
            r_scan     <= n_scan;
            r_active   <= n_active;
            r_periodic <= n_periodic;
        end
        r_ev_idx     <= n_ev_idx;
        r_best       <= n_best;
        r_best_exp   <= n_best_exp;
        r_best_stamp <= n_best_stamp;
        r_best_per   <= n_best_per;
        r_sum_a      <= n_sum_a;
        r_sum_b      <= n_sum_b;
        r_id         <= n_id;
    end

    `MST_ASSERT_NOW(a_fired_is_active, o_valid, r_active[r_best])
    `MST_ASSERT_NOW(a_fired_is_due, o_valid, r_best_exp <= r_now)
    `MST_ASSERT_NOW(a_fired_in_budget, o_valid, r_fired < r_due)
    `MST_ASSERT_NEXT(a_strobe_spaced, o_valid, !o_valid)
endmodule
